### rtl/core/spq_pkg.sv
// Shared types, codes and defaults for the sorted priority queue.
`default_nettype none

package spq_pkg;

	// Request codes
	localparam logic MODE_ENQ = 1'b0;
	localparam logic MODE_DEQ = 1'b1;

	// Fixed field widths of the request and response
	localparam int PRIO_W      = 32;
	localparam int PAY_IO_W    = 32;
	localparam int COUNT_OUT_W = 5;

	// Defaults for the top-level parameters
	localparam int DEPTH_DEF         = 16;
	localparam int PAYLOAD_WIDTH_DEF = 32;

	typedef struct packed {
		logic                       mode;
		logic [PAY_IO_W-1:0]        payload;
		logic signed [PRIO_W-1:0]   priority_req;
	} req_t;

	typedef struct packed {
		logic [PAY_IO_W-1:0]    out_payload;
		logic                   empty_error;
		logic                   full_error;
		logic [COUNT_OUT_W-1:0] count_after;
	} rsp_t;

	// Per-cycle command broadcast to every cell
	typedef struct packed {
		logic enq;
		logic deq;
	} cell_ctl_t;

endpackage

`default_nettype wire

### rtl/core/spq_cell.sv
// One slot of the sorted register row: holds a priority and payload.
`default_nettype none

module spq_cell
	import spq_pkg::*;
#(
	parameter int PW = 32
) (
	input  wire logic                     clk,
	input  wire cell_ctl_t                ctl,
	input  wire logic                     occupied,
	input  wire logic signed [PRIO_W-1:0] new_prio,
	input  wire logic [PW-1:0]            new_pay,
	input  wire logic                     left_ge,
	input  wire logic signed [PRIO_W-1:0] left_prio,
	input  wire logic [PW-1:0]            left_pay,
	input  wire logic signed [PRIO_W-1:0] right_prio,
	input  wire logic [PW-1:0]            right_pay,
	output logic                          ge,
	output logic signed [PRIO_W-1:0]      prio_q,
	output logic [PW-1:0]                 pay_q
);

	// Empty slots count as "not lower" so the insert point falls at the tail
	assign ge = !occupied || (prio_q >= new_prio);

	// Insert: slots past the insert point shift up, the insert point loads new.
	// Remove: every slot takes its upper neighbor.
	always_ff @(posedge clk) begin
		if (ctl.enq) begin
			if (left_ge) begin
				prio_q <= left_prio;
				pay_q  <= left_pay;
			end else if (ge) begin
				prio_q <= new_prio;
				pay_q  <= new_pay;
			end
		end else if (ctl.deq) begin
			prio_q <= right_prio;
			pay_q  <= right_pay;
		end
	end

endmodule

`default_nettype wire

### rtl/core/sorted_priority_queue.sv
// Sorted priority queue built as a row of compare-and-shift cells.
//
// Requests come in on req (valid/stall); each is an enqueue (mode 0) with a
// payload and signed priority, or a dequeue (mode 1) of the lowest priority.
// Every request yields exactly one response on rsp: the removed payload, an
// empty or full flag, and the entry count after the request.
// Every cell compares its own priority with the incoming one and either holds,
// loads the new entry, or takes its neighbor's entry, all on the same clock edge.
// rsp_valid rises in the cycle after acceptance; one request per cycle is
// taken as long as the response register drains. The compare in each cell
// and the neighbor mux set the cycle time.
// req_stall is high while a response is held and rsp_stall is high; the queue
// row and the response then hold still.
// Reset empties the queue (count to zero) and clears rsp_valid; the slot
// contents are not cleared, since only slots below the count are read.
`default_nettype none

module sorted_priority_queue
	import spq_pkg::*;
#(
	parameter int DEPTH         = DEPTH_DEF,
	parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = (PAYLOAD_WIDTH < PAY_IO_W) ? PAYLOAD_WIDTH : PAY_IO_W;

	logic [CW-1:0]            count_q;
	logic                     rsp_valid_q;
	rsp_t                     rsp_q;
	logic                     accept;
	logic                     is_enq;
	logic                     full;
	logic                     empty;
	cell_ctl_t                ctl;
	logic [CW-1:0]            count_nxt;
	logic [SW-1:0]            new_pay;
	logic [SW+PAY_IO_W-1:0]   head_ext;
	logic [CW+COUNT_OUT_W-1:0] count_ext;

	logic signed [PRIO_W-1:0] prio_arr [DEPTH];
	logic [SW-1:0]            pay_arr  [DEPTH];
	logic [DEPTH-1:0]         ge_vec;

	// Handshake and command decode
	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;
	assign is_enq    = (req.mode == MODE_ENQ);
	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign ctl.enq   = accept && is_enq && !full;
	assign ctl.deq   = accept && !is_enq && !empty;
	assign new_pay   = req.payload[SW-1:0];

	always_comb begin
		count_nxt = count_q;
		if (ctl.enq) begin
			count_nxt = count_q + 1'b1;
		end else if (ctl.deq) begin
			count_nxt = count_q - 1'b1;
		end
	end

	assign head_ext  = {{PAY_IO_W{1'b0}}, pay_arr[0]};
	assign count_ext = {{COUNT_OUT_W{1'b0}}, count_nxt};

	// Cell row
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                     l_ge;
		logic signed [PRIO_W-1:0] l_prio;
		logic [SW-1:0]            l_pay;
		logic signed [PRIO_W-1:0] r_prio;
		logic [SW-1:0]            r_pay;

		if (i == 0) begin : g_first
			assign l_ge   = 1'b0;
			assign l_prio = req.priority_req;
			assign l_pay  = new_pay;
		end else begin : g_mid
			assign l_ge   = ge_vec[i-1];
			assign l_prio = prio_arr[i-1];
			assign l_pay  = pay_arr[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign r_prio = prio_arr[i];
			assign r_pay  = pay_arr[i];
		end else begin : g_inner
			assign r_prio = prio_arr[i+1];
			assign r_pay  = pay_arr[i+1];
		end

		spq_cell #(
			.PW(SW)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occupied  (count_q > CW'(i)),
			.new_prio  (req.priority_req),
			.new_pay   (new_pay),
			.left_ge   (l_ge),
			.left_prio (l_prio),
			.left_pay  (l_pay),
			.right_prio(r_prio),
			.right_pay (r_pay),
			.ge        (ge_vec[i]),
			.prio_q    (prio_arr[i]),
			.pay_q     (pay_arr[i])
		);
	end

	// Count and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.out_payload <= ctl.deq ? head_ext[PAY_IO_W-1:0] : '0;
			rsp_q.empty_error <= !is_enq && empty;
			rsp_q.full_error  <= is_enq && full;
			rsp_q.count_after <= count_ext[COUNT_OUT_W-1:0];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.enq || ctl.deq) |=> $stable(count_q))
		else $error("count moved without a queue update");

	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp_valid)
		else $error("accepted request gave no response");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= CW'(2) |-> prio_arr[0] <= prio_arr[1])
		else $error("head entries out of order");

endmodule

`default_nettype wire
